FILE: rtl/keyed_table_with_aging_unit_defines.svh
// Assertion macros shared by the keyed table RTL.
`ifndef KEYED_TABLE_WITH_AGING_UNIT_DEFINES_SVH
`define KEYED_TABLE_WITH_AGING_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define KTAB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyed table: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define KTAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyed table: next-cycle check failed");

`endif

FILE: rtl/ktab_pkg.sv
// Types and constants shared by the keyed table modules.
package ktab_pkg;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_SWEEP  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic [31:0] MIN_VALID_TIME = 32'd1000000;
    localparam logic [31:0] MAX_AGE_RESET  = 32'd86400;

    typedef struct packed {
        logic [31:0] age;
        logic        expired;
    } t_age_res;

endpackage

FILE: rtl/ktab_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ktab_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/ktab_age.sv
// Age of a stored stamp against the current time, and the expiry test.
module ktab_age import ktab_pkg::*; (
    input  logic [31:0] i_stamp,
    input  logic [31:0] i_now,
    input  logic [31:0] i_max_age,
    output t_age_res    o_res
);

    logic clk_valid;
    logic stamped;

    always_comb begin
        clk_valid = (i_now >= MIN_VALID_TIME);
        // A zero stamp or one ahead of the current time has no age.
        stamped   = (i_stamp != 32'd0) && (i_stamp <= i_now);
        o_res.age = (clk_valid && stamped) ? (i_now - i_stamp) : 32'd0;
        o_res.expired = (o_res.age > i_max_age);
    end

endmodule

FILE: rtl/keyed_table_with_aging_unit.sv
// Top level of the keyed table with time-stamp aging.
//
// Usage: a command beat is taken at a rising edge where start is high and
// busy is low. i_command selects write, lookup, remove or sweep; i_key,
// i_value and i_now travel with it. Exactly one result beat follows: o_done
// is high for one cycle with o_status, o_value_out, o_age and o_count. The
// receiver cannot stall, so the result is only shown for that one cycle.
//
// All entries live in one RAM with a registered read. Write, lookup and
// remove walk the stored entries from the first, one entry per cycle; a
// remove that moves the last entry into the freed slot then passes through
// S_MOVE. o_done rises in the cycle after the final step. Sweep walks from
// the last entry down, one entry per cycle, except that each entry moved
// passes through S_SWMOVE as well. A sweep with an invalid clock or an
// empty table answers in the next cycle.
// busy stays low during the result beat, so the next command can enter
// there. The max_age register is written through i_cfg_we/i_cfg_data; the
// user must do so only while the block is idle, as the block does not
// enforce it. Reset empties the table and loads max_age with its default;
// the RAM contents are not cleared, since only filled slots are read.
`include "keyed_table_with_aging_unit_defines.svh"

module keyed_table_with_aging_unit import ktab_pkg::*; #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [63:0] i_key,
    input  logic [63:0] i_value,
    input  logic [31:0] i_now,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [63:0] o_value_out,
    output logic [31:0] o_age,
    output logic [4:0]  o_count
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int XW = IW + 1;
    localparam int EW = KEY_BITS + VALUE_BITS + 32;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_MOVE   = 3'd2;
    localparam logic [2:0] S_SWEEP  = 3'd3;
    localparam logic [2:0] S_SWMOVE = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [1:0]            r_cmd, n_cmd;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [31:0]           r_now, n_now;
    logic [IW-1:0]         r_idx, n_idx;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [31:0]           r_max_age;
    logic                  r_done, n_done;
    logic [1:0]            r_status, n_status;
    logic [63:0]           r_vout, n_vout;
    logic [31:0]           r_age, n_age;

    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;
    logic [EW-1:0]         mem_wdata;
    logic [IW-1:0]         mem_raddr;
    logic [EW-1:0]         mem_rdata;

    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic [31:0]           rd_stamp;
    t_age_res              age_res;

    logic                  hit;
    logic                  at_last;
    logic                  table_full;
    logic [IW-1:0]         last_addr;

    ktab_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Each RAM word holds key, value and stamp, key at the top.
    assign rd_key   = mem_rdata[EW-1 -: KEY_BITS];
    assign rd_val   = mem_rdata[32 +: VALUE_BITS];
    assign rd_stamp = mem_rdata[31:0];

    ktab_age u_age (
        .i_stamp   (rd_stamp),
        .i_now     (r_now),
        .i_max_age (r_max_age),
        .o_res     (age_res)
    );

    // While scanning or sweeping, the read data belongs to the entry at r_idx.
    assign hit        = (r_cnt != '0) && (rd_key == r_key);
    assign at_last    = ((XW'(r_idx) + 1'b1) >= XW'(r_cnt));
    assign table_full = (r_cnt == CW'(ENTRIES));
    assign last_addr  = IW'(r_cnt - 1'b1);

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_val     = r_val;
        n_now     = r_now;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_done    = 1'b0;
        n_status  = r_status;
        n_vout    = r_vout;
        n_age     = r_age;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = mem_rdata;
        mem_raddr = r_idx;

        unique case (r_state)
            S_IDLE: begin
                mem_raddr = '0;
                if (start) begin
                    n_cmd = i_command;
                    n_key = i_key[KEY_BITS-1:0];
                    n_val = i_value[VALUE_BITS-1:0];
                    n_now = i_now;
                    if (i_command == CMD_SWEEP) begin
                        if ((i_now < MIN_VALID_TIME) || (r_cnt == '0)) begin
                            // Nothing to walk: answer right away.
                            n_done   = 1'b1;
                            n_status = ST_OK;
                            n_vout   = '0;
                            n_age    = '0;
                        end else begin
                            n_idx     = last_addr;
                            mem_raddr = last_addr;
                            n_state   = S_SWEEP;
                        end
                    end else begin
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (hit) begin
                    n_done   = 1'b1;
                    n_status = ST_OK;
                    n_vout   = '0;
                    n_age    = '0;
                    n_state  = S_IDLE;
                    unique case (r_cmd)
                        CMD_WRITE: begin
                            mem_we    = 1'b1;
                            mem_waddr = r_idx;
                            mem_wdata = {r_key, r_val, r_now};
                        end
                        CMD_LOOKUP: begin
                            n_vout = 64'(rd_val);
                            n_age  = age_res.age;
                        end
                        CMD_REMOVE: begin
                            if (at_last) begin
                                n_cnt = r_cnt - 1'b1;
                            end else begin
                                // Fetch the last entry to fill the hole.
                                n_done    = 1'b0;
                                mem_raddr = last_addr;
                                n_state   = S_MOVE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end else if (at_last) begin
                    n_done  = 1'b1;
                    n_vout  = '0;
                    n_age   = '0;
                    n_state = S_IDLE;
                    if (r_cmd == CMD_WRITE) begin
                        if (table_full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_status  = ST_OK;
                            mem_we    = 1'b1;
                            mem_waddr = IW'(r_cnt);
                            mem_wdata = {r_key, r_val, r_now};
                            n_cnt     = r_cnt + 1'b1;
                        end
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end else begin
                    n_idx     = r_idx + 1'b1;
                    mem_raddr = r_idx + 1'b1;
                end
            end

            S_MOVE: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = mem_rdata;
                n_cnt     = r_cnt - 1'b1;
                n_done    = 1'b1;
                n_status  = ST_OK;
                n_state   = S_IDLE;
            end

            S_SWEEP: begin
                if (age_res.expired && !at_last) begin
                    mem_raddr = last_addr;
                    n_state   = S_SWMOVE;
                end else begin
                    if (age_res.expired) begin
                        n_cnt = r_cnt - 1'b1;
                    end
                    if (r_idx == '0) begin
                        n_done   = 1'b1;
                        n_status = ST_OK;
                        n_vout   = '0;
                        n_age    = '0;
                        n_state  = S_IDLE;
                    end else begin
                        n_idx     = r_idx - 1'b1;
                        mem_raddr = r_idx - 1'b1;
                    end
                end
            end

            S_SWMOVE: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = mem_rdata;
                n_cnt     = r_cnt - 1'b1;
                if (r_idx == '0) begin
                    n_done   = 1'b1;
                    n_status = ST_OK;
                    n_vout   = '0;
                    n_age    = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_idx     = r_idx - 1'b1;
                    mem_raddr = r_idx - 1'b1;
                    n_state   = S_SWEEP;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_done    <= 1'b0;
            r_max_age <= MAX_AGE_RESET;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_max_age <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_val    <= n_val;
        r_now    <= n_now;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_vout   <= n_vout;
        r_age    <= n_age;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_value_out = r_vout;
    assign o_age       = r_age;
    assign o_count     = 5'(r_cnt);

    // The table never holds more entries than it has slots.
    `KTAB_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(ENTRIES))
    // A result beat is never shown while a command is still being worked.
    `KTAB_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    // Each result beat comes from a command that was accepted or in work.
    `KTAB_ASSERT_NOW(a_done_src, i_clk, i_rst_n, o_done, $past(busy) || $past(start))
    // With no command in flight and none accepted, the fill count holds.
    `KTAB_ASSERT_NEXT(a_cnt_hold, i_clk, i_rst_n, !busy && !start, $stable(r_cnt))

endmodule
